>>> hw/rtl/yns_pkg.sv
// ----------------------------------------------------------------------------
// yns_pkg - shared types and constants for the numeric scalar classifier
// Scan phases, result kinds, token state layout and character codes.
// ----------------------------------------------------------------------------
package yns_pkg;

  localparam int MaxIntDigits   = 18;
  localparam int MaxFloatLength = 60;

  localparam int AccW = 60;
  localparam int LenW = 6;
  localparam int CntW = 5;
  localparam int ValW = 61;

  localparam logic [LenW-1:0] LenSat = '1;
  localparam logic [CntW-1:0] CntSat = '1;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChExpLo = 8'h65;
  localparam logic [7:0] ChExpUp = 8'h45;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_MINUS      = 3'd1,
    PH_INT        = 3'd2,
    PH_FRAC       = 3'd3,
    PH_EXP_MARK   = 3'd4,
    PH_EXP_SIGN   = 3'd5,
    PH_EXP_DIGITS = 3'd6,
    PH_REJECT     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   acc;
    logic              minus;
    logic [LenW-1:0]   len;
    logic [CntW-1:0]   cnt;
    logic              lz;
  } tok_t;

  localparam tok_t TokClear = '{PH_START, '0, 1'b0, '0, '0, 1'b0};

endpackage

>>> hw/rtl/yns_scan.sv
// ----------------------------------------------------------------------------
// yns_scan - input register and per-character token scanner
// Registers each incoming word, then steps the grammar state and the
// decimal accumulator. On the final character the stepped state is handed
// to the classifier and the token state clears.
// ----------------------------------------------------------------------------
module yns_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             fin_free,
  output logic             fin_load,
  output yns_pkg::tok_t    fin_tok
);

  logic             in_valid_r;
  logic [7:0]       char_r;
  logic             last_r;
  yns_pkg::tok_t    tok_r;
  yns_pkg::tok_t    tok_nxt;
  yns_pkg::tok_t    adv;
  logic             s1_go;
  logic             digit;
  logic             take_dig;
  logic [3:0]       dval;

  assign s1_go     = in_valid_r && (!last_r || fin_free);
  assign in_tready = !in_valid_r || s1_go;
  assign fin_load  = s1_go && last_r;
  assign fin_tok   = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_comb begin
    adv      = tok_r;
    digit    = (char_r >= yns_pkg::ChZero) && (char_r <= yns_pkg::ChNine);
    dval     = char_r[3:0];
    take_dig = 1'b0;
    adv.phase = yns_pkg::PH_REJECT;
    case (tok_r.phase)
      yns_pkg::PH_START: begin
        if (char_r == yns_pkg::ChMinus) begin
          adv.minus = 1'b1;
          adv.phase = yns_pkg::PH_MINUS;
        end else if (digit) begin
          take_dig  = 1'b1;
          adv.phase = yns_pkg::PH_INT;
        end
      end
      yns_pkg::PH_MINUS: begin
        if (digit) begin
          take_dig  = 1'b1;
          adv.phase = yns_pkg::PH_INT;
        end
      end
      yns_pkg::PH_INT: begin
        if (digit) begin
          take_dig  = 1'b1;
          adv.phase = yns_pkg::PH_INT;
        end else if (char_r == yns_pkg::ChDot) begin
          adv.phase = yns_pkg::PH_FRAC;
        end
      end
      yns_pkg::PH_FRAC: begin
        if (digit) begin
          adv.phase = yns_pkg::PH_FRAC;
        end else if (char_r inside {yns_pkg::ChExpLo, yns_pkg::ChExpUp}) begin
          adv.phase = yns_pkg::PH_EXP_MARK;
        end
      end
      yns_pkg::PH_EXP_MARK: begin
        if (char_r inside {yns_pkg::ChPlus, yns_pkg::ChMinus}) begin
          adv.phase = yns_pkg::PH_EXP_SIGN;
        end
      end
      yns_pkg::PH_EXP_SIGN, yns_pkg::PH_EXP_DIGITS: begin
        if (digit) begin
          adv.phase = yns_pkg::PH_EXP_DIGITS;
        end
      end
      default: begin
        adv.phase = yns_pkg::PH_REJECT;
      end
    endcase

    if (take_dig) begin
      if (tok_r.cnt == '0) begin
        adv.lz = (dval == 4'd0);
      end
      // acc*10 + d as two shifts and two adds; 18 digits never overflow 60 bits
      if (tok_r.cnt < yns_pkg::CntW'(yns_pkg::MaxIntDigits)) begin
        adv.acc = (tok_r.acc << 3) + (tok_r.acc << 1) + yns_pkg::AccW'(dval);
      end
      if (tok_r.cnt != yns_pkg::CntSat) begin
        adv.cnt = tok_r.cnt + 1'b1;
      end
    end

    if (tok_r.len != yns_pkg::LenSat) begin
      adv.len = tok_r.len + 1'b1;
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    if (s1_go) begin
      tok_nxt = last_r ? yns_pkg::TokClear : adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= yns_pkg::TokClear;
    end else begin
      tok_r <= tok_nxt;
    end
  end

endmodule

>>> hw/rtl/yns_classify.sv
// ----------------------------------------------------------------------------
// yns_classify - final token classification and result register
// Holds the stepped state of a finished token, decides integer / float /
// other, forms the signed value and drives the result channel.
// ----------------------------------------------------------------------------
module yns_classify (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fin_load,
  input  yns_pkg::tok_t    fin_tok,
  output logic             fin_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,
  output logic [1:0]       out_tuser
);

  logic                       fin_valid_r;
  yns_pkg::tok_t              fin_r;
  logic                       fin_go;
  logic                       out_valid_r;
  yns_pkg::kind_t             kind_r;
  yns_pkg::kind_t             kind_nxt;
  logic [yns_pkg::ValW-1:0]   value_r;
  logic [yns_pkg::ValW-1:0]   value_nxt;
  logic [yns_pkg::ValW-1:0]   mag;
  logic                       is_int;
  logic                       is_float;

  assign fin_go   = !out_valid_r || out_tready;
  assign fin_free = !fin_valid_r || fin_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= fin_load;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load && fin_free) begin
      fin_r <= fin_tok;
    end
  end

  always_comb begin
    mag      = {1'b0, fin_r.acc};
    // a leading zero followed by more digits is octal, left to software
    is_int   = (fin_r.phase == yns_pkg::PH_INT) && (fin_r.cnt != '0) &&
               (fin_r.cnt <= yns_pkg::CntW'(yns_pkg::MaxIntDigits)) &&
               !((fin_r.cnt > yns_pkg::CntW'(1)) && fin_r.lz);
    is_float = ((fin_r.phase == yns_pkg::PH_FRAC) ||
                (fin_r.phase == yns_pkg::PH_EXP_DIGITS)) &&
               (fin_r.len >= yns_pkg::LenW'(2)) &&
               (fin_r.len <= yns_pkg::LenW'(yns_pkg::MaxFloatLength));
    kind_nxt  = yns_pkg::KIND_OTHER;
    value_nxt = '0;
    if (is_int) begin
      kind_nxt  = yns_pkg::KIND_INT;
      value_nxt = fin_r.minus ? ('0 - mag) : mag;
    end else if (is_float) begin
      kind_nxt  = yns_pkg::KIND_FLOAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && fin_valid_r) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, value_r};
  assign out_tuser  = kind_r;

endmodule

>>> hw/rtl/yaml_numeric_scalar_classifier.sv
// ----------------------------------------------------------------------------
// yaml_numeric_scalar_classifier - plain scalar int / float / other resolver
// Throughput: one character word per cycle while in_tready is high. Three
// register stages (input, token snapshot, result) each move on their own ready,
// so input keeps flowing while a result waits on out_tready, until a final
// character meets a full token snapshot.
// Reset: rst_n synchronous, clears each stage's valid flag and the token state.
// ----------------------------------------------------------------------------
module yaml_numeric_scalar_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [60:0] int_value, [63:61] zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic             fin_free;
  logic             fin_load;
  yns_pkg::tok_t    fin_tok;

  yns_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fin_free  (fin_free),
    .fin_load  (fin_load),
    .fin_tok   (fin_tok)
  );

  yns_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_load   (fin_load),
    .fin_tok    (fin_tok),
    .fin_free   (fin_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hw/rtl/yns_checker.sv
// ----------------------------------------------------------------------------
// yns_checker - port-level checks for the numeric scalar classifier
// Watches the result channel for legal kinds, zero values on non-integers,
// stable words under backpressure and no valid result right after reset.
// ----------------------------------------------------------------------------
module yns_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser
);

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == yns_pkg::KIND_INT ||
                    out_tuser == yns_pkg::KIND_FLOAT ||
                    out_tuser == yns_pkg::KIND_OTHER))
    else $error("result word carries an undefined kind");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != yns_pkg::KIND_INT) |->
      (out_tdata == '0))
    else $error("non-integer result carries a value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind yaml_numeric_scalar_classifier yns_checker u_yns_checker (.*);

>>> tb/yaml_numeric_scalar_classifier_test.sv
// ----------------------------------------------------------------------------
// yaml_numeric_scalar_classifier_test - self-checking bench for the classifier
// Streams character words of plain scalar tokens (directed corner tokens, then
// random well-formed ints and floats, mutated tokens and byte noise) with
// random idling on both sides. A token model predicts one verdict per final
// character; verdicts are compared in order against the result stream.
// ----------------------------------------------------------------------------
module yaml_numeric_scalar_classifier_test;

  localparam int ItemTarget = 1500;
  localparam int CalmTail   = 250;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 3000;
  localparam int PrintCap   = 50;

  class scalar_verdicts;
    typedef struct {
      yns_pkg::kind_t           kind;
      logic [yns_pkg::ValW-1:0] value;
    } verdict_t;

    yns_pkg::phase_t          phase;
    logic [yns_pkg::AccW-1:0] acc;
    bit                       minus;
    logic [yns_pkg::LenW-1:0] len;
    logic [yns_pkg::CntW-1:0] cnt;
    bit                       lz;
    verdict_t                 expected_verdicts[$];
    int                       errors;

    function new();
      clear_token();
      errors = 0;
    endfunction

    function void clear_token();
      phase = yns_pkg::PH_START;
      acc   = '0;
      minus = 1'b0;
      len   = '0;
      cnt   = '0;
      lz    = 1'b0;
    endfunction

    function void take_digit(logic [3:0] d);
      if (cnt == 0) lz = (d == 0);
      // magnitude stops growing past the integer digit limit
      if (cnt < yns_pkg::MaxIntDigits) acc = acc * 10 + yns_pkg::AccW'(d);
      if (cnt != yns_pkg::CntSat) cnt = cnt + 1'b1;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      bit                       is_digit;
      yns_pkg::phase_t          nxt;
      verdict_t                 v;
      logic [yns_pkg::ValW-1:0] mag;
      is_digit = (c >= yns_pkg::ChZero) && (c <= yns_pkg::ChNine);
      nxt = yns_pkg::PH_REJECT;
      case (phase)
        yns_pkg::PH_START: begin
          if (c == yns_pkg::ChMinus) begin
            minus = 1'b1;
            nxt = yns_pkg::PH_MINUS;
          end else if (is_digit) begin
            take_digit(4'(c - yns_pkg::ChZero));
            nxt = yns_pkg::PH_INT;
          end
        end
        yns_pkg::PH_MINUS: begin
          if (is_digit) begin
            take_digit(4'(c - yns_pkg::ChZero));
            nxt = yns_pkg::PH_INT;
          end
        end
        yns_pkg::PH_INT: begin
          if (is_digit) begin
            take_digit(4'(c - yns_pkg::ChZero));
            nxt = yns_pkg::PH_INT;
          end else if (c == yns_pkg::ChDot) begin
            nxt = yns_pkg::PH_FRAC;
          end
        end
        yns_pkg::PH_FRAC: begin
          if (is_digit) nxt = yns_pkg::PH_FRAC;
          else if (c == yns_pkg::ChExpLo || c == yns_pkg::ChExpUp)
            nxt = yns_pkg::PH_EXP_MARK;
        end
        yns_pkg::PH_EXP_MARK: begin
          if (c == yns_pkg::ChPlus || c == yns_pkg::ChMinus) nxt = yns_pkg::PH_EXP_SIGN;
        end
        yns_pkg::PH_EXP_SIGN, yns_pkg::PH_EXP_DIGITS: begin
          if (is_digit) nxt = yns_pkg::PH_EXP_DIGITS;
        end
        default: ;
      endcase
      phase = nxt;
      if (len != yns_pkg::LenSat) len = len + 1'b1;
      if (!last) return;

      v.kind  = yns_pkg::KIND_OTHER;
      v.value = '0;
      if (phase == yns_pkg::PH_INT && cnt >= 1 && cnt <= yns_pkg::MaxIntDigits &&
          !(cnt > 1 && lz)) begin
        mag     = yns_pkg::ValW'(acc);
        v.kind  = yns_pkg::KIND_INT;
        v.value = minus ? -mag : mag;
      end else if ((phase == yns_pkg::PH_FRAC || phase == yns_pkg::PH_EXP_DIGITS) &&
                   len >= 2 && len <= yns_pkg::MaxFloatLength) begin
        v.kind = yns_pkg::KIND_FLOAT;
      end
      expected_verdicts.push_back(v);
      clear_token();
    endfunction

    task report(string msg);
      if (errors < PrintCap) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(logic [63:0] word, logic [1:0] kind);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result word %h kind %0d", word, kind));
        return;
      end
      v = expected_verdicts.pop_front();
      if (kind !== v.kind)
        report($sformatf("kind %0d, expected %0d", kind, v.kind));
      if (word[60:0] !== v.value)
        report($sformatf("int_value %0d, expected %0d",
                         $signed(word[60:0]), $signed(v.value)));
      if (word[63:61] !== 3'b000)
        report("pad bits of result word set");
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  scalar_verdicts sb = new();
  logic [7:0]     tok[$];
  int             chars_sent = 0;
  int             stall_cycles = 0;
  bit             no_idle = 1'b0;
  bit             start_hold = 1'b0;
  bit             hold_done = 1'b0;

  yaml_numeric_scalar_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- token builders -------------------------------------------------------
  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
  endfunction

  function automatic void add_digits(int n, bit lead_nonzero);
    for (int i = 0; i < n; i++)
      tok.push_back(8'(yns_pkg::ChZero + ((i == 0 && lead_nonzero) ? $urandom_range(1, 9)
                                                                   : $urandom_range(0, 9))));
  endfunction

  function automatic void make_int();
    int n;
    int r;
    if ($urandom_range(0, 2) == 0) tok.push_back(yns_pkg::ChMinus);
    r = $urandom_range(0, 9);
    n = (r == 0) ? $urandom_range(19, 24) :
        (r == 1) ? yns_pkg::MaxIntDigits : $urandom_range(1, 17);
    if ($urandom_range(0, 7) == 0) begin
      tok.push_back(yns_pkg::ChZero);
      add_digits(n - 1, 1'b0);
    end else begin
      add_digits(n, 1'b1);
    end
  endfunction

  function automatic void make_float(bit long_one);
    int target;
    if ($urandom_range(0, 2) == 0) tok.push_back(yns_pkg::ChMinus);
    add_digits($urandom_range(1, 4), 1'($urandom_range(0, 1)));
    tok.push_back(yns_pkg::ChDot);
    if (long_one) begin
      // lengths around the float length limit and the length saturation
      target = $urandom_range(yns_pkg::MaxFloatLength - 3, 66);
      if (target > tok.size()) add_digits(target - tok.size(), 1'b0);
      return;
    end
    add_digits($urandom_range(0, 5), 1'b0);
    if ($urandom_range(0, 1) == 0) begin
      tok.push_back($urandom_range(0, 1) ? yns_pkg::ChExpLo : yns_pkg::ChExpUp);
      if ($urandom_range(0, 7) != 0)
        tok.push_back($urandom_range(0, 1) ? yns_pkg::ChPlus : yns_pkg::ChMinus);
      add_digits(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3), 1'b0);
    end
  endfunction

  function automatic void mutate();
    int idx;
    idx = $urandom_range(0, tok.size() - 1);
    case ($urandom_range(0, 2))
      0: tok[idx] = 8'($urandom_range(0, 255));
      1: if (tok.size() > 1) tok.delete(idx);
      default: tok.insert(idx, 8'($urandom_range(0, 255)));
    endcase
  endfunction

  // ---- drivers --------------------------------------------------------------
  task automatic send_char(logic [7:0] c, logic last);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    chars_sent++;
    if (chars_sent >= ItemTarget - CalmTail) no_idle = 1'b1;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok.size(); i++) send_char(tok[i], i == tok.size() - 1);
    tok.delete();
  endtask

  task automatic send_str(string s);
    push_str(s);
    send_token();
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : receiver
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (start_hold && !hold_done) begin
        hold_done  = 1'b1;
        out_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // ---- monitor and watchdog -------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---- stimulus -------------------------------------------------------------
  initial begin : stimulus
    int pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // corner tokens
    send_str("0");
    send_str("-0");
    send_str("7");
    send_str("-");
    send_str("999999999999999999");
    send_str("-999999999999999999");
    send_str("1234567890123456789");   // one digit too many
    send_str("00");
    send_str("-01");
    send_str("1.");
    send_str("-0.5");
    send_str("3.25e+10");
    send_str("1.5E-7");
    send_str("1.5e10");                // exponent without sign
    send_str("2.0e+");                 // exponent without digits
    send_str("1.2.3");
    send_str(".5");
    send_str("+1");
    tok.push_back(8'h00);
    send_token();
    tok.push_back(8'hFF);
    tok.push_back(8'hFF);
    send_token();
    add_digits(35, 1'b1);              // digit counter saturates
    send_token();
    add_digits(35, 1'b1);
    tok.push_back(yns_pkg::ChDot);
    send_token();
    push_str("1.");
    add_digits(yns_pkg::MaxFloatLength - 2, 1'b0);
    send_token();
    push_str("1.");
    add_digits(yns_pkg::MaxFloatLength - 1, 1'b0);
    send_token();
    push_str("-1.");
    add_digits(70, 1'b0);              // length counter saturates
    send_token();

    start_hold = 1'b1;
    while (chars_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        make_int();
      end else if (pick < 75) begin
        make_float(1'b0);
      end else if (pick < 87) begin
        if ($urandom_range(0, 1)) make_int();
        else make_float(1'b0);
        mutate();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
      end else begin
        make_float(1'b1);
      end
      send_token();
    end
    in_tvalid = 1'b0;

    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
